// ----- rtl/core/prr_pkg.sv -----
// ----------------------------------------------------------------------------
// prr_pkg
// Shared widths and constants for the PageRank engine.
// ----------------------------------------------------------------------------
package prr_pkg;

	localparam int unsigned NODE_FW   = 6;
	localparam int unsigned RANK_W    = 32;
	localparam int unsigned PWR_W     = 8;
	localparam logic [PWR_W-1:0]  PWR_RESET = 8'd2;
	localparam logic [RANK_W-1:0] RANK_ONE  = 32'h8000_0000;

	localparam logic MODE_INSERT  = 1'b0;
	localparam logic MODE_COMPUTE = 1'b1;

endpackage

// ----- rtl/core/prr_if.sv -----
// ----------------------------------------------------------------------------
// prr_in_if / prr_out_if
// Valid/ready channels for edge/compute requests and rank results.
// ----------------------------------------------------------------------------
interface prr_in_if;
	logic                           valid;
	logic                           ready;
	logic                           mode;
	logic [prr_pkg::NODE_FW-1:0]    source_node;
	logic [prr_pkg::NODE_FW-1:0]    dest_node;

	modport source (output valid, mode, source_node, dest_node, input ready);
	modport sink   (input valid, mode, source_node, dest_node, output ready);
endinterface

interface prr_out_if;
	logic                           valid;
	logic                           ready;
	logic [prr_pkg::NODE_FW-1:0]    node_index;
	logic [prr_pkg::RANK_W-1:0]     rank_value;
	logic                           last_of_run;
	logic                           graph_empty;
	logic                           edges_dropped;

	modport source (output valid, node_index, rank_value, last_of_run, graph_empty,
		edges_dropped, input ready);
	modport sink   (input valid, node_index, rank_value, last_of_run, graph_empty,
		edges_dropped, output ready);
endinterface

// ----- rtl/core/pagerank_power_iteration.sv -----
// ----------------------------------------------------------------------------
// pagerank_power_iteration
// Undamped PageRank over an edge table held in on-chip memory.
// ----------------------------------------------------------------------------
// Input channel in_ch: mode 0 inserts edge source_node -> dest_node (no result),
// mode 1 computes ranks and streams one result per present node on out_ch in
// ascending index order, last_of_run on the final one. An empty graph gives one
// result with graph_empty set. cfg_we/cfg_wdata write power_iterations.
// One item at a time: a new request is accepted only while idle. A compute
// runs the seed division, seeds every node index, then per round divides
// each stored edge's source rank by its degree (the bit-serial divider
// dominates) and copies the round's sums for every index, then reads out
// present nodes and skips absent indices.
// Reset clears the edge count, degrees, node marks and the drop flag; the
// edge table and rank memories need no clearing. A stalled receiver holds
// the output register and the readout waits on it; no result is lost.
// ----------------------------------------------------------------------------
module pagerank_power_iteration #(
	parameter int unsigned MAX_NODES = 64,
	parameter int unsigned MAX_EDGES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [prr_pkg::PWR_W-1:0]  cfg_wdata,
	prr_in_if.sink                     in_ch,
	prr_out_if.source                  out_ch
);

	localparam int unsigned NW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int unsigned CW   = $clog2(MAX_NODES + 1);
	localparam int unsigned EW   = $clog2(MAX_EDGES);
	localparam int unsigned ECW  = $clog2(MAX_EDGES + 1);
	localparam int unsigned DVW  = (ECW > CW) ? ECW : CW;
	localparam int unsigned RW   = prr_pkg::RANK_W;

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_INS_WR = 5'd1;
	localparam logic [4:0] ST_EMPTY  = 5'd2;
	localparam logic [4:0] ST_SEED_D = 5'd3;
	localparam logic [4:0] ST_SEED_W = 5'd4;
	localparam logic [4:0] ST_RND    = 5'd5;
	localparam logic [4:0] ST_E_RD   = 5'd6;
	localparam logic [4:0] ST_E_SRC  = 5'd7;
	localparam logic [4:0] ST_E_LD   = 5'd8;
	localparam logic [4:0] ST_E_DIV  = 5'd9;
	localparam logic [4:0] ST_E_WR   = 5'd10;
	localparam logic [4:0] ST_CP_RD  = 5'd11;
	localparam logic [4:0] ST_CP_WR  = 5'd12;
	localparam logic [4:0] ST_OUT_RD = 5'd13;
	localparam logic [4:0] ST_OUT_LD = 5'd14;

	logic [4:0]                state_q;
	logic [prr_pkg::PWR_W-1:0] pwr_q;
	logic [prr_pkg::PWR_W-1:0] round_q;
	logic [ECW-1:0]            edge_cnt_q;
	logic [ECW-1:0]            eidx_q;
	logic                      ovf_q;
	logic [MAX_NODES-1:0]      present_q;
	logic [MAX_NODES-1:0]      deg_vld_q;
	logic [MAX_NODES-1:0]      acc_vld_q;
	logic [CW-1:0]             node_cnt_q;
	logic [CW-1:0]             v_q;
	logic [CW-1:0]             emit_q;
	logic [NW-1:0]             src_q;
	logic [NW-1:0]             dst_q;
	logic [RW-1:0]             seed_q;

	// output register
	logic                        ov_q;
	logic [prr_pkg::NODE_FW-1:0] o_idx_q;
	logic [RW-1:0]               o_rank_q;
	logic                        o_last_q;
	logic                        o_empty_q;
	logic                        o_drop_q;

	// node memories
	logic [ECW-1:0] deg_mem [MAX_NODES];
	logic [RW-1:0]  cur_mem [MAX_NODES];
	logic [RW-1:0]  acc_mem [MAX_NODES];
	logic [ECW-1:0] deg_rd_q;
	logic [RW-1:0]  cur_rd_q;
	logic [RW-1:0]  acc_rd_q;

	logic           deg_we, cur_we, acc_we;
	logic [NW-1:0]  deg_ra, cur_ra, acc_ra, cur_wa;
	logic [ECW-1:0] deg_wd;
	logic [RW-1:0]  cur_wd, acc_wd;

	logic [prr_pkg::NODE_FW-1:0] e_src, e_dst;
	logic                        e_we;

	logic           div_start;
	logic           div_done;
	logic [RW-1:0]  div_num;
	logic [DVW-1:0] div_den;
	logic [RW-1:0]  div_quo;

	logic           in_acc;
	logic           out_free;
	logic           out_load;
	logic           node_ok;
	logic [NW-1:0]  in_s, in_d, v_idx;
	logic [CW-1:0]  new_nodes;
	logic [ECW-1:0] deg_eff;
	logic [RW-1:0]  acc_eff;
	logic           v_last;
	logic           e_last;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_free    = !ov_q || out_ch.ready;
	assign out_load    = out_free && ((state_q == ST_EMPTY) || (state_q == ST_OUT_LD));
	assign in_s        = in_ch.source_node[NW-1:0];
	assign in_d        = in_ch.dest_node[NW-1:0];
	assign node_ok     = (32'(in_ch.source_node) < MAX_NODES) &&
		(32'(in_ch.dest_node) < MAX_NODES);
	assign new_nodes   = CW'(!present_q[in_s]) + CW'(!present_q[in_d] && (in_s != in_d));
	assign v_idx       = v_q[NW-1:0];
	assign v_last      = (v_q == CW'(MAX_NODES - 1));
	assign e_last      = (eidx_q + 1'b1 == edge_cnt_q);
	assign deg_eff     = deg_vld_q[src_q] ? deg_rd_q : '0;
	assign acc_eff     = acc_vld_q[v_idx] ? acc_rd_q : '0;

	prr_edge_mem #(.DEPTH(MAX_EDGES), .AW(EW)) u_edges (
		.clk   (clk),
		.we    (e_we),
		.waddr (edge_cnt_q[EW-1:0]),
		.wsrc  (in_ch.source_node),
		.wdst  (in_ch.dest_node),
		.raddr (eidx_q[EW-1:0]),
		.rsrc  (e_src),
		.rdst  (e_dst)
	);

	prr_div #(.NUM_W(RW), .DEN_W(DVW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// memory port control
	always_comb begin
		e_we      = 1'b0;
		div_start = 1'b0;
		div_num   = cur_rd_q;
		div_den   = DVW'(deg_eff);
		deg_we = 1'b0;
		deg_ra = src_q;
		deg_wd = deg_eff + 1'b1;
		cur_we = 1'b0;
		cur_ra = v_idx;
		cur_wa = v_idx;
		cur_wd = '0;
		acc_we = 1'b0;
		acc_ra = v_idx;
		acc_wd = (acc_vld_q[dst_q] ? acc_rd_q : '0) + div_quo;
		unique case (state_q)
			ST_IDLE: begin
				deg_ra = in_s;
				e_we   = in_acc && (in_ch.mode == prr_pkg::MODE_INSERT) && node_ok &&
					(edge_cnt_q != ECW'(MAX_EDGES));
				div_num = prr_pkg::RANK_ONE;
				div_den = DVW'(node_cnt_q);
				div_start = in_acc && (in_ch.mode == prr_pkg::MODE_COMPUTE) &&
					(node_cnt_q != '0);
			end
			ST_INS_WR: deg_we = 1'b1;
			ST_SEED_W: begin
				cur_we = 1'b1;
				cur_wd = present_q[v_idx] ? seed_q : '0;
			end
			ST_E_SRC: begin
				cur_ra = e_src[NW-1:0];
				deg_ra = e_src[NW-1:0];
			end
			ST_E_LD:  div_start = (deg_eff != '0);
			ST_E_DIV: acc_ra = dst_q;
			ST_E_WR: begin
				acc_ra = dst_q;
				acc_we = 1'b1;
			end
			ST_CP_WR: begin
				cur_we = 1'b1;
				cur_wd = !present_q[v_idx] ? '0 :
					(acc_eff > prr_pkg::RANK_ONE) ? prr_pkg::RANK_ONE : acc_eff;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[src_q] <= deg_wd;
		end
		deg_rd_q <= deg_mem[deg_ra];
		if (cur_we) begin
			cur_mem[cur_wa] <= cur_wd;
		end
		cur_rd_q <= cur_mem[cur_ra];
		if (acc_we) begin
			acc_mem[dst_q] <= acc_wd;
		end
		acc_rd_q <= acc_mem[acc_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pwr_q      <= prr_pkg::PWR_RESET;
			round_q    <= '0;
			edge_cnt_q <= '0;
			eidx_q     <= '0;
			ovf_q      <= 1'b0;
			present_q  <= '0;
			deg_vld_q  <= '0;
			acc_vld_q  <= '0;
			node_cnt_q <= '0;
			v_q        <= '0;
			emit_q     <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				pwr_q <= cfg_wdata;
			end
			ov_q <= out_load || (ov_q && !out_ch.ready);
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_ch.mode == prr_pkg::MODE_INSERT) begin
							if (node_ok) begin
								if (edge_cnt_q == ECW'(MAX_EDGES)) begin
									ovf_q <= 1'b1;
								end else begin
									edge_cnt_q        <= edge_cnt_q + 1'b1;
									present_q[in_s]   <= 1'b1;
									present_q[in_d]   <= 1'b1;
									node_cnt_q        <= node_cnt_q + new_nodes;
									state_q           <= ST_INS_WR;
								end
							end
						end else if (node_cnt_q == '0) begin
							state_q <= ST_EMPTY;
						end else begin
							state_q <= ST_SEED_D;
						end
					end
				end
				ST_INS_WR: begin
					deg_vld_q[src_q] <= 1'b1;
					state_q          <= ST_IDLE;
				end
				ST_EMPTY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SEED_D: begin
					v_q     <= '0;
					round_q <= 8'd1;
					if (div_done) begin
						state_q <= ST_SEED_W;
					end
				end
				ST_SEED_W: begin
					v_q <= v_q + 1'b1;
					if (v_last) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					v_q    <= '0;
					emit_q <= '0;
					eidx_q <= '0;
					if (round_q < pwr_q) begin
						acc_vld_q <= '0;
						state_q   <= (edge_cnt_q == '0) ? ST_CP_RD : ST_E_RD;
					end else begin
						state_q <= ST_OUT_RD;
					end
				end
				ST_E_RD:  state_q <= ST_E_SRC;
				ST_E_SRC: state_q <= ST_E_LD;
				ST_E_LD: begin
					if (deg_eff != '0) begin
						state_q <= ST_E_DIV;
					end else begin
						eidx_q  <= eidx_q + 1'b1;
						state_q <= e_last ? ST_CP_RD : ST_E_RD;
					end
				end
				ST_E_DIV: begin
					if (div_done) begin
						state_q <= ST_E_WR;
					end
				end
				ST_E_WR: begin
					acc_vld_q[dst_q] <= 1'b1;
					eidx_q           <= eidx_q + 1'b1;
					state_q          <= e_last ? ST_CP_RD : ST_E_RD;
				end
				ST_CP_RD: state_q <= ST_CP_WR;
				ST_CP_WR: begin
					if (v_last) begin
						round_q <= round_q + 1'b1;
						state_q <= ST_RND;
					end else begin
						v_q     <= v_q + 1'b1;
						state_q <= ST_CP_RD;
					end
				end
				ST_OUT_RD: begin
					if (present_q[v_idx]) begin
						state_q <= ST_OUT_LD;
					end else if (v_last) begin
						state_q <= ST_IDLE;
					end else begin
						v_q <= v_q + 1'b1;
					end
				end
				ST_OUT_LD: begin
					if (out_free) begin
						emit_q <= emit_q + 1'b1;
						if (emit_q + 1'b1 == node_cnt_q) begin
							state_q <= ST_IDLE;
						end else begin
							v_q     <= v_q + 1'b1;
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			src_q <= in_s;
		end
		if (state_q == ST_E_SRC) begin
			src_q <= e_src[NW-1:0];
			dst_q <= e_dst[NW-1:0];
		end
		if (state_q == ST_SEED_D && div_done) begin
			seed_q <= div_quo;
		end
		if (state_q == ST_EMPTY && out_free) begin
			o_idx_q   <= '0;
			o_rank_q  <= '0;
			o_last_q  <= 1'b1;
			o_empty_q <= 1'b1;
			o_drop_q  <= ovf_q;
		end
		if (state_q == ST_OUT_LD && out_free) begin
			o_idx_q   <= prr_pkg::NODE_FW'(v_idx);
			o_rank_q  <= cur_rd_q;
			o_last_q  <= (emit_q + 1'b1 == node_cnt_q);
			o_empty_q <= 1'b0;
			o_drop_q  <= ovf_q;
		end
	end

	assign out_ch.valid         = ov_q;
	assign out_ch.node_index    = o_idx_q;
	assign out_ch.rank_value    = o_rank_q;
	assign out_ch.last_of_run   = o_last_q;
	assign out_ch.graph_empty   = o_empty_q;
	assign out_ch.edges_dropped = o_drop_q;

endmodule

// ----- rtl/core/prr_edge_mem.sv -----
// ----------------------------------------------------------------------------
// prr_edge_mem
// Edge table: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module prr_edge_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [prr_pkg::NODE_FW-1:0] wsrc,
	input  logic [prr_pkg::NODE_FW-1:0] wdst,
	input  logic [AW-1:0]               raddr,
	output logic [prr_pkg::NODE_FW-1:0] rsrc,
	output logic [prr_pkg::NODE_FW-1:0] rdst
);

	logic [2*prr_pkg::NODE_FW-1:0] mem [DEPTH];
	logic [2*prr_pkg::NODE_FW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wsrc, wdst};
		end
		rd_q <= mem[raddr];
	end

	assign rsrc = rd_q[2*prr_pkg::NODE_FW-1:prr_pkg::NODE_FW];
	assign rdst = rd_q[prr_pkg::NODE_FW-1:0];

endmodule

// ----- rtl/core/prr_div.sv -----
// ----------------------------------------------------------------------------
// prr_div
// Restoring divider, one quotient bit per cycle, floor result.
// ----------------------------------------------------------------------------
module prr_div #(
	parameter int unsigned NUM_W = 32,
	parameter int unsigned DEN_W = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NUM_W-1:0]      num,
	input  logic [DEN_W-1:0]      den,
	output logic                  done,
	output logic [NUM_W-1:0]      quo
);

	localparam int unsigned CNT_W = $clog2(NUM_W);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign fits   = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (run_q) begin
			rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
